/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SSE_ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define SSE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* design/sse_pkg.sv */
// Package: constants, state encoding and control structs of the sort engine.
`default_nettype none

package sse_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SETUP,
		ST_PASS,
		ST_FIRST,
		ST_SCAN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_EMIT,
		ST_CAP
	} sse_state_t;

	typedef struct packed {
		logic load;
		logic pass_rd;
		logic first;
		logic scan;
		logic scan_rd;
		logic swap_a;
		logic swap_b;
		logic emit_rd;
		logic emit_cap;
	} sse_cmd_t;

	typedef struct packed {
		logic one_elem;
		logic scan_more;
		logic pass_last;
		logic emit_last;
		logic out_free;
	} sse_sts_t;

endpackage

`default_nettype wire

/* design/sse_intf.sv */
// Channel interfaces: input element channel and sorted result channel.
`default_nettype none

interface sse_in_if import sse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;
	logic                     last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface sse_out_if import sse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     final_res;
	logic                     dropped;

	modport source (output valid, output sorted_value, output final_res, output dropped,
		input ready);
	modport sink (input valid, input sorted_value, input final_res, input dropped,
		output ready);
endinterface

`default_nettype wire

/* design/selection_sort_engine_unit.sv */
// Top level: selection sort engine, controller plus datapath.
// Load: one element per cycle while in_ch.ready is high; the last-marked item closes the set.
// Sort of n elements: one compare per cycle, over n-1 selection passes (PASS, FIRST, SCAN, SWAP_A, SWAP_B).
// Emit: each result is read from the store (EMIT), then captured in the output register (CAP); out_ch stalls hold EMIT.
// The next set may start loading while the final result still waits in the output register.
// arst_n clears the FSM, counters and output valid; the element store is not cleared.
`default_nettype none

module selection_sort_engine_unit import sse_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sse_in_if.sink     in_ch,
	sse_out_if.source  out_ch
);

	sse_cmd_t cmd;
	sse_sts_t sts;
	logic     in_ready;

	assign in_ch.ready = in_ready;

	sse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_last  (in_ch.last),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sse_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_value    (in_ch.value),
		.in_last     (in_ch.last),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_value   (out_ch.sorted_value),
		.out_final   (out_ch.final_res),
		.out_dropped (out_ch.dropped)
	);

endmodule

`default_nettype wire

/* design/sse_ctrl.sv */
// Controller FSM: load, selection passes, swaps and result emission.
`default_nettype none

module sse_ctrl import sse_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_last,
	output logic          in_ready,
	input  wire sse_sts_t sts,
	output sse_cmd_t      cmd
);

	sse_state_t state_q;
	sse_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_valid && in_last) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = sts.one_elem ? ST_EMIT : ST_PASS;
			end
			ST_PASS:   state_d = ST_FIRST;
			ST_FIRST:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (!sts.scan_more) state_d = ST_SWAP_A;
			end
			ST_SWAP_A: state_d = ST_SWAP_B;
			ST_SWAP_B: begin
				state_d = sts.pass_last ? ST_EMIT : ST_PASS;
			end
			ST_EMIT: begin
				if (sts.out_free) state_d = ST_CAP;
			end
			ST_CAP: begin
				state_d = sts.emit_last ? ST_LOAD : ST_EMIT;
			end
			default:   state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_PASS:   cmd.pass_rd = 1'b1;
			ST_FIRST:  cmd.first   = 1'b1;
			ST_SCAN: begin
				cmd.scan    = 1'b1;
				cmd.scan_rd = sts.scan_more;
			end
			ST_SWAP_A: cmd.swap_a   = 1'b1;
			ST_SWAP_B: cmd.swap_b   = 1'b1;
			ST_EMIT:   cmd.emit_rd  = sts.out_free;
			ST_CAP:    cmd.emit_cap = 1'b1;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/sse_dpath.sv */
// Datapath: element store, min tracking, pass/scan/emit counters, output register.
`default_nettype none

module sse_dpath import sse_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire sse_cmd_t                 cmd,
	output sse_sts_t                      sts,
	input  wire logic signed [DATA_W-1:0] in_value,
	input  wire logic                     in_last,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      out_value,
	output logic                          out_final,
	output logic                          out_dropped
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;
	logic [AW-1:0]            raddr;
	logic [AW-1:0]            waddr;
	logic signed [DATA_W-1:0] wdata;
	logic                     we;

	logic [CW-1:0]            count_q;
	logic                     ovf_q;
	logic [CW-1:0]            n_q;
	logic                     drop_q;
	logic [AW-1:0]            i_q;
	logic [CW-1:0]            j_q;
	logic [AW-1:0]            k_q;
	logic [AW-1:0]            jidx_s1;
	logic signed [DATA_W-1:0] min_val_q;
	logic [AW-1:0]            min_idx_q;
	logic signed [DATA_W-1:0] vali_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic                     out_final_q;
	logic                     out_dropped_q;
	logic                     full;

	assign full = (count_q == CW'(DEPTH));

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = in_value;
		if (cmd.load && !full) begin
			we = 1'b1;
		end else if (cmd.swap_a) begin
			we    = 1'b1;
			waddr = min_idx_q;
			wdata = vali_q;
		end else if (cmd.swap_b) begin
			we    = 1'b1;
			waddr = i_q;
			wdata = min_val_q;
		end
	end

	always_comb begin
		if (cmd.pass_rd) begin
			raddr = i_q;
		end else if (cmd.emit_rd) begin
			raddr = k_q;
		end else begin
			raddr = j_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			n_q     <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.load) begin
				if (in_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					n_q     <= full ? count_q : count_q + CW'(1);
					drop_q  <= ovf_q | full;
					i_q     <= '0;
					k_q     <= '0;
				end else if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.pass_rd) j_q <= CW'(i_q) + CW'(1);
			if (cmd.first || cmd.scan_rd) j_q <= j_q + CW'(1);
			if (cmd.swap_b) i_q <= i_q + AW'(1);
			if (cmd.emit_cap) k_q <= k_q + AW'(1);
		end
	end

	// running minimum of the current pass
	always_ff @(posedge clk) begin
		if (cmd.first) begin
			min_val_q <= rdata_q;
			min_idx_q <= i_q;
			vali_q    <= rdata_q;
		end else if (cmd.scan && (rdata_q < min_val_q)) begin
			min_val_q <= rdata_q;
			min_idx_q <= jidx_s1;
		end
		if (cmd.first || cmd.scan_rd) jidx_s1 <= j_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_cap) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_cap) begin
			out_value_q   <= rdata_q;
			out_final_q   <= sts.emit_last;
			out_dropped_q <= drop_q;
		end
	end

	assign sts.one_elem  = (n_q == CW'(1));
	assign sts.scan_more = (j_q < n_q);
	assign sts.pass_last = ((CW'(i_q) + CW'(2)) == n_q);
	assign sts.emit_last = ((CW'(k_q) + CW'(1)) == n_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign out_final   = out_final_q;
	assign out_dropped = out_dropped_q;

endmodule

`default_nettype wire

/* design/sse_checker.sv */
// Port-level checker for the sort engine and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module sse_checker import sse_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              in_last,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [DATA_W-1:0] out_value,
	input wire logic              out_final,
	input wire logic              out_dropped
);

	`SSE_ASSERT_PROP(a_close_blocks_input, clk, arst_n, (in_valid && in_ready && in_last) |=> !in_ready, "input still ready after set closed")

	`SSE_ASSERT_NEVER(a_no_load_mid_emit, clk, arst_n, out_valid && !out_final && in_ready, "input ready while set still emitting")

	`SSE_ASSERT_PROP(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_final) && $stable(out_dropped)), "stalled result changed")

endmodule

bind selection_sort_engine_unit sse_checker u_sse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_last     (in_ch.last),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_value   (out_ch.sorted_value),
	.out_final   (out_ch.final_res),
	.out_dropped (out_ch.dropped)
);

`default_nettype wire
